FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file of the scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLIES(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

`define ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`define ASSERT_NEXT_ALWAYS(name, clk, pre, post) \
   name: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

FILE: hdl/hrfs_pkg.sv
// Types and constants of the HPACK request field scanner.
package hrfs_pkg;

   localparam int FRAME_HEADER_BYTES = 9;
   localparam int LENGTH_FIELD_BYTES = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int POSITION_WIDTH = 24;
   localparam int NAME_INDEX_WIDTH = 6;
   localparam logic [NAME_INDEX_WIDTH-1:0] LENGTH_INDEX_RESET = 6'd28;
   localparam logic [31:0] ASCII_ZERO = 32'd48;

   localparam logic [6:0] INDEX_GET = 7'd2;
   localparam logic [6:0] INDEX_POST = 7'd3;
   localparam logic [6:0] INDEX_ROOT = 7'd4;
   localparam logic [6:0] INDEX_INDEX_HTML = 7'd5;

   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_UNSUPPORTED = 1'b1;

   typedef enum logic [1:0] {
      KIND_INDEXED     = 2'd0,
      KIND_LITERAL     = 2'd1,
      KIND_UNSUPPORTED = 2'd2
   } kind_type;

   typedef enum logic [4:0] {
      PHASE_IDLE    = 5'b00001,
      PHASE_HEADER  = 5'b00010,
      PHASE_REP     = 5'b00100,
      PHASE_STRLEN  = 5'b01000,
      PHASE_STRBODY = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0]                  frame_byte;
      logic                        first_byte;
      kind_type                    kind;
      logic [NAME_INDEX_WIDTH-1:0] name_index;
   } entry_type;

   typedef struct packed {
      logic [1:0]  method;
      logic [1:0]  path_kind;
      logic [31:0] decimal_length;
      logic        length_seen;
      logic        length_huffman;
      logic        status;
   } result_type;

endpackage

FILE: hdl/hpack_request_field_scanner_unit.sv
// Top level of the HPACK request field scanner.
// The req channel takes one byte of an HTTP/2 HEADERS frame per item, frame
// header first, with req_tuser set on the first byte of each frame. The rsp
// channel gives one item per frame: when the header block has been consumed,
// or at once when an unsupported representation stops the scan. A frame with
// a zero-length block gives its item on the last frame header byte.
// The csr channel writes the name index whose literal value is the content
// length; it is always ready and should be written only while the block idles.
// A byte is classified on entry and placed in a four-item queue; the back end
// takes one item per cycle from the queue unless rsp is stalled, so the block
// sustains one byte per cycle. The queue and the rsp result are both registered.
// When rsp is stalled, the back end holds while its result waits, and the
// queue keeps taking bytes until it is full, then req_tready falls.
// Reset clears the queue, the scan state and the result valid flag, and sets
// the name index to 28; the block idles until a byte with req_tuser set.
module hpack_request_field_scanner_unit #(
   parameter int QUEUE_DEPTH = hrfs_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] frame_byte
   input  logic        req_tuser,   // [0] first_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [1:0] method, [3:2] path_kind,
                                    // [35:4] decimal_length, [36] length_seen,
                                    // [37] length_huffman, [39:38] zero
   output logic        rsp_tuser,   // [0] status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [5:0]  csr_data     // [5:0] length_name_index
);

   hrfs_pkg::entry_type  push_entry;
   hrfs_pkg::entry_type  pop_entry;
   hrfs_pkg::result_type result;
   logic                 push, queue_full, pop, pop_valid;

   assign csr_ready = 1'b1;

   hrfs_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   hrfs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   hrfs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   assign rsp_tdata = {2'b00, result.length_huffman, result.length_seen,
                       result.decimal_length, result.path_kind, result.method};
   assign rsp_tuser = result.status;

endmodule

FILE: hdl/hrfs_front.sv
// Front part: accepts input bytes and classifies their representation form.
module hrfs_front (
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                req_tuser,
   input  logic                queue_full,
   output logic                push,
   output hrfs_pkg::entry_type push_entry
);

   logic [7:0] b;

   assign b          = req_tdata;
   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   always_comb begin
      push_entry.frame_byte = b;
      push_entry.first_byte = req_tuser;
      if (b[7]) begin
         push_entry.kind       = hrfs_pkg::KIND_INDEXED;
         push_entry.name_index = b[5:0];
      end else if (b[6]) begin
         push_entry.kind       = hrfs_pkg::KIND_LITERAL;
         push_entry.name_index = b[5:0];
      end else if (!b[5]) begin
         push_entry.kind       = hrfs_pkg::KIND_LITERAL;
         push_entry.name_index = {2'b00, b[3:0]};
      end else begin
         push_entry.kind       = hrfs_pkg::KIND_UNSUPPORTED;
         push_entry.name_index = b[5:0];
      end
   end

endmodule

FILE: hdl/hrfs_queue.sv
// Small queue of classified items between the front and back parts.
module hrfs_queue #(
   parameter int DEPTH = hrfs_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hrfs_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                pop_valid,
   output hrfs_pkg::entry_type pop_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   hrfs_pkg::entry_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == FULL_COUNT);
   assign pop_valid = (count_ff != '0);
   assign pop_entry = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: hdl/hrfs_back.sv
// Back part: walks the header block, collects the fields and holds the result.
module hrfs_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [5:0]           csr_data,
   input  logic                 pop_valid,
   input  hrfs_pkg::entry_type  pop_entry,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output hrfs_pkg::result_type rsp_result
);

   localparam int PW = hrfs_pkg::POSITION_WIDTH;
   localparam logic [PW-1:0] LAST_HEADER_POS = PW'(hrfs_pkg::FRAME_HEADER_BYTES - 1);
   localparam logic [PW-1:0] LENGTH_BYTES = PW'(hrfs_pkg::LENGTH_FIELD_BYTES);

   logic [hrfs_pkg::NAME_INDEX_WIDTH-1:0] length_index_ff;

   hrfs_pkg::phase_type phase_ff, phase_in;
   logic [PW-1:0]       position_ff, position_in;
   logic [PW-1:0]       block_length_ff, block_length_in;
   logic [6:0]          skip_ff, skip_in;
   logic                name_literal_ff, name_literal_in;
   logic                accumulating_ff, accumulating_in;
   logic [1:0]          method_ff, method_in;
   logic [1:0]          path_ff, path_in;
   logic [31:0]         length_value_ff, length_value_in;
   logic                seen_ff, seen_in;
   logic                huffman_ff, huffman_in;
   logic                rsp_valid_ff, rsp_valid_in;
   hrfs_pkg::result_type rsp_ff, rsp_in;

   logic       emit;
   logic       status;
   logic       stop;
   logic [7:0] b;
   logic [6:0] idx;

   assign pop        = pop_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;
   assign b          = pop_entry.frame_byte;
   assign idx        = b[6:0];

   always_comb begin
      phase_in        = phase_ff;
      position_in     = position_ff;
      block_length_in = block_length_ff;
      skip_in         = skip_ff;
      name_literal_in = name_literal_ff;
      accumulating_in = accumulating_ff;
      method_in       = method_ff;
      path_in         = path_ff;
      length_value_in = length_value_ff;
      seen_in         = seen_ff;
      huffman_in      = huffman_ff;
      emit            = 1'b0;
      status          = hrfs_pkg::STATUS_DONE;
      stop            = 1'b0;

      if (pop && pop_entry.first_byte) begin
         phase_in        = hrfs_pkg::PHASE_HEADER;
         position_in     = '0;
         block_length_in = '0;
         skip_in         = '0;
         name_literal_in = 1'b0;
         accumulating_in = 1'b0;
         method_in       = '0;
         path_in         = '0;
         length_value_in = '0;
         seen_in         = 1'b0;
         huffman_in      = 1'b0;
      end

      if (pop && phase_in != hrfs_pkg::PHASE_IDLE) begin
         if (phase_in == hrfs_pkg::PHASE_HEADER) begin
            if (position_in < LENGTH_BYTES) begin
               block_length_in = {block_length_in[PW-9:0], b};
            end
            if (position_in == LAST_HEADER_POS) begin
               position_in = '0;
               phase_in    = hrfs_pkg::PHASE_REP;
               if (block_length_in == '0) begin
                  emit = 1'b1;
               end
            end else begin
               position_in = position_in + 1'b1;
            end
         end else begin
            case (phase_in)
               hrfs_pkg::PHASE_REP: begin
                  case (pop_entry.kind)
                     hrfs_pkg::KIND_INDEXED: begin
                        if (method_in == '0 &&
                            (idx == hrfs_pkg::INDEX_GET || idx == hrfs_pkg::INDEX_POST)) begin
                           method_in = idx[1:0] - 2'd1;
                        end
                        if (path_in == '0 &&
                            (idx == hrfs_pkg::INDEX_ROOT ||
                             idx == hrfs_pkg::INDEX_INDEX_HTML)) begin
                           path_in = idx[1:0] + 2'd1;
                        end
                     end
                     hrfs_pkg::KIND_LITERAL: begin
                        if (pop_entry.name_index == '0) begin
                           name_literal_in = 1'b1;
                           accumulating_in = 1'b0;
                        end else begin
                           name_literal_in = 1'b0;
                           accumulating_in = (pop_entry.name_index == length_index_ff) &&
                                             !seen_in;
                        end
                        phase_in = hrfs_pkg::PHASE_STRLEN;
                     end
                     default: begin
                        emit   = 1'b1;
                        status = hrfs_pkg::STATUS_UNSUPPORTED;
                        stop   = 1'b1;
                     end
                  endcase
               end
               hrfs_pkg::PHASE_STRLEN: begin
                  skip_in = b[6:0];
                  if (accumulating_in) begin
                     seen_in = 1'b1;
                     if (b[7]) begin
                        huffman_in      = 1'b1;
                        accumulating_in = 1'b0;
                     end
                  end
                  if (skip_in == '0) begin
                     if (name_literal_in) begin
                        name_literal_in = 1'b0;
                        phase_in        = hrfs_pkg::PHASE_STRLEN;
                     end else begin
                        accumulating_in = 1'b0;
                        phase_in        = hrfs_pkg::PHASE_REP;
                     end
                  end else begin
                     phase_in = hrfs_pkg::PHASE_STRBODY;
                  end
               end
               hrfs_pkg::PHASE_STRBODY: begin
                  if (accumulating_in) begin
                     length_value_in = (length_value_in << 3) + (length_value_in << 1)
                                       + {24'd0, b} - hrfs_pkg::ASCII_ZERO;
                  end
                  skip_in = skip_in - 1'b1;
                  if (skip_in == '0) begin
                     if (name_literal_in) begin
                        name_literal_in = 1'b0;
                        phase_in        = hrfs_pkg::PHASE_STRLEN;
                     end else begin
                        accumulating_in = 1'b0;
                        phase_in        = hrfs_pkg::PHASE_REP;
                     end
                  end
               end
               default: begin
                  phase_in = hrfs_pkg::PHASE_IDLE;
               end
            endcase
            if (!stop) begin
               position_in = position_in + 1'b1;
               if (position_in == block_length_in) begin
                  emit = 1'b1;
               end
            end
         end
      end

      if (emit) begin
         phase_in = hrfs_pkg::PHASE_IDLE;
      end

      rsp_in.method         = method_in;
      rsp_in.path_kind      = path_in;
      rsp_in.decimal_length = huffman_in ? 32'd0 : length_value_in;
      rsp_in.length_seen    = seen_in;
      rsp_in.length_huffman = huffman_in;
      rsp_in.status         = status;

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_index_ff <= hrfs_pkg::LENGTH_INDEX_RESET;
         phase_ff        <= hrfs_pkg::PHASE_IDLE;
         position_ff     <= '0;
         block_length_ff <= '0;
         skip_ff         <= '0;
         name_literal_ff <= 1'b0;
         accumulating_ff <= 1'b0;
         method_ff       <= '0;
         path_ff         <= '0;
         length_value_ff <= '0;
         seen_ff         <= 1'b0;
         huffman_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid) begin
            length_index_ff <= csr_data;
         end
         phase_ff        <= phase_in;
         position_ff     <= position_in;
         block_length_ff <= block_length_in;
         skip_ff         <= skip_in;
         name_literal_ff <= name_literal_in;
         accumulating_ff <= accumulating_in;
         method_ff       <= method_in;
         path_ff         <= path_in;
         length_value_ff <= length_value_in;
         seen_ff         <= seen_in;
         huffman_ff      <= huffman_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

FILE: hdl/hrfs_checker.sv
// Port-level checks of the scanner and their binding to the top level.
`include "assert_macros.svh"

module hrfs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tuser
);

   logic        stalled;
   logic [40:0] rsp_word;
   logic        codes_ok;
   logic        huffman_ok;

   assign stalled    = rsp_tvalid && !rsp_tready;
   assign rsp_word   = {rsp_tuser, rsp_tdata};
   assign codes_ok   = (rsp_tdata[1:0] != 2'd3) && (rsp_tdata[3:2] != 2'd3)
                       && (rsp_tdata[39:38] == 2'd0);
   assign huffman_ok = !rsp_tdata[37] || (rsp_tdata[36] && (rsp_tdata[35:4] == 32'd0));

   `ASSERT_NEXT_ALWAYS(reset_clears_result, clock, reset, !rsp_tvalid)
   `ASSERT_NEXT(stalled_result_holds, clock, reset, stalled, rsp_tvalid && $stable(rsp_word))
   `ASSERT_IMPLIES(codes_in_range, clock, reset, rsp_tvalid, codes_ok)
   `ASSERT_IMPLIES(huffman_means_seen, clock, reset, rsp_tvalid, huffman_ok)

endmodule

bind hpack_request_field_scanner_unit hrfs_checker u_checker (.*);

FILE: tb/testbench.sv
// Self-checking stream testbench for the HPACK request field scanner.
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned SETTLE_CYCLES = 16;
   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam int unsigned LONG_GAP = 30;
   localparam int unsigned ITEM_TARGET = 1600;
   localparam int unsigned PHASES = 8;

   localparam logic [1:0] METHOD_NONE = 2'd0;
   localparam logic [1:0] METHOD_GET = 2'd1;
   localparam logic [1:0] METHOD_POST = 2'd2;
   localparam logic [1:0] PATH_NONE = 2'd0;
   localparam logic [1:0] PATH_ROOT = 2'd1;
   localparam logic [1:0] PATH_INDEX_HTML = 2'd2;

   typedef enum logic [1:0] {
      PLAN_BYTE,
      PLAN_DRAIN,
      PLAN_CSR
   } plan_kind_type;

   typedef struct {
      plan_kind_type kind;
      logic [7:0]    value;
      logic          first;
   } plan_entry_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [5:0]  csr_data = 6'd0;

   plan_entry_type       send_plan[$];
   hrfs_pkg::result_type field_reports[$];
   int unsigned plan_bytes = 0;
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;
   int unsigned settle_count = 0;
   int unsigned idle_cycles = 0;
   int unsigned cycle_count = 0;
   logic        stim_done = 1'b0;
   logic        mismatch_seen = 1'b0;

   hrfs_pkg::phase_type scan_phase;
   logic [23:0] header_count;
   logic [23:0] payload_length;
   logic [6:0]  string_left;
   logic        name_pending;
   logic        digits_active;
   logic [1:0]  method_found;
   logic [1:0]  path_found;
   logic [31:0] digits_value;
   logic        length_found;
   logic        length_coded;
   logic [5:0]  length_index_model;

   hpack_request_field_scanner_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (cycle_count[11:10] == 2'b11) return 0;
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, LONG_GAP);
   endfunction

   function automatic void clear_scan();
      scan_phase = hrfs_pkg::PHASE_IDLE;
      header_count = '0;
      payload_length = '0;
      string_left = '0;
      name_pending = 1'b0;
      digits_active = 1'b0;
      method_found = METHOD_NONE;
      path_found = PATH_NONE;
      digits_value = '0;
      length_found = 1'b0;
      length_coded = 1'b0;
   endfunction

   function automatic void report_fields(input logic status);
      hrfs_pkg::result_type r;
      r.method = method_found;
      r.path_kind = path_found;
      r.decimal_length = length_coded ? 32'd0 : digits_value;
      r.length_seen = length_found;
      r.length_huffman = length_coded;
      r.status = status;
      field_reports.push_back(r);
      scan_phase = hrfs_pkg::PHASE_IDLE;
   endfunction

   function automatic void start_literal(input logic [5:0] name_index);
      if (name_index == 6'd0) begin
         name_pending = 1'b1;
         digits_active = 1'b0;
      end else begin
         name_pending = 1'b0;
         digits_active = (name_index == length_index_model) && !length_found;
      end
      scan_phase = hrfs_pkg::PHASE_STRLEN;
   endfunction

   function automatic void finish_string();
      if (name_pending) begin
         name_pending = 1'b0;
         scan_phase = hrfs_pkg::PHASE_STRLEN;
      end else begin
         digits_active = 1'b0;
         scan_phase = hrfs_pkg::PHASE_REP;
      end
   endfunction

   function automatic void scan_byte(input logic [7:0] b, input logic first);
      logic [6:0] table_index;
      if (first) begin
         clear_scan();
         scan_phase = hrfs_pkg::PHASE_HEADER;
      end else if (scan_phase == hrfs_pkg::PHASE_IDLE) begin
         return;
      end
      if (scan_phase == hrfs_pkg::PHASE_HEADER) begin
         if (header_count < hrfs_pkg::LENGTH_FIELD_BYTES)
            payload_length = {payload_length[15:0], b};
         if (header_count + 1 >= hrfs_pkg::FRAME_HEADER_BYTES) begin
            header_count = '0;
            scan_phase = hrfs_pkg::PHASE_REP;
            if (payload_length == 24'd0) report_fields(hrfs_pkg::STATUS_DONE);
         end else begin
            header_count = header_count + 24'd1;
         end
         return;
      end
      case (scan_phase)
         hrfs_pkg::PHASE_REP: begin
            if (b[7]) begin
               table_index = b[6:0];
               if (method_found == METHOD_NONE && table_index == hrfs_pkg::INDEX_GET)
                  method_found = METHOD_GET;
               if (method_found == METHOD_NONE && table_index == hrfs_pkg::INDEX_POST)
                  method_found = METHOD_POST;
               if (path_found == PATH_NONE && table_index == hrfs_pkg::INDEX_ROOT)
                  path_found = PATH_ROOT;
               if (path_found == PATH_NONE && table_index == hrfs_pkg::INDEX_INDEX_HTML)
                  path_found = PATH_INDEX_HTML;
            end else if (b[6]) begin
               start_literal(b[5:0]);
            end else if (!b[5]) begin
               start_literal({2'b00, b[3:0]});
            end else begin
               report_fields(hrfs_pkg::STATUS_UNSUPPORTED);
               return;
            end
         end
         hrfs_pkg::PHASE_STRLEN: begin
            string_left = b[6:0];
            if (digits_active) begin
               length_found = 1'b1;
               if (b[7]) begin
                  length_coded = 1'b1;
                  digits_active = 1'b0;
               end
            end
            if (string_left == 7'd0) finish_string();
            else scan_phase = hrfs_pkg::PHASE_STRBODY;
         end
         default: begin
            if (digits_active)
               digits_value = digits_value * 32'd10 + b - hrfs_pkg::ASCII_ZERO;
            string_left = string_left - 7'd1;
            if (string_left == 7'd0) finish_string();
         end
      endcase
      header_count = header_count + 24'd1;
      if (header_count == payload_length) report_fields(hrfs_pkg::STATUS_DONE);
   endfunction

   function automatic void check_field(input string label, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         mismatch_seen = 1'b1;
      end
   endfunction

   task automatic add_item(input logic [7:0] value, input logic first);
      send_plan.push_back('{PLAN_BYTE, value, first});
      plan_bytes++;
   endtask

   task automatic add_drain();
      send_plan.push_back('{PLAN_DRAIN, 8'd0, 1'b0});
   endtask

   task automatic add_csr(input logic [5:0] name_index);
      send_plan.push_back('{PLAN_CSR, {2'b00, name_index}, 1'b0});
   endtask

   task automatic push_frame(input logic [7:0] body[$], input logic [23:0] length);
      add_item(length[23:16], 1'b1);
      add_item(length[15:8], 1'b0);
      add_item(length[7:0], 1'b0);
      repeat (hrfs_pkg::FRAME_HEADER_BYTES - hrfs_pkg::LENGTH_FIELD_BYTES)
         add_item(8'($urandom_range(0, 255)), 1'b0);
      foreach (body[i]) add_item(body[i], 1'b0);
   endtask

   task automatic add_string(ref logic [7:0] body[$], input logic digits);
      int unsigned count;
      count = ($urandom_range(0, 99) < 4) ? $urandom_range(11, 127) : $urandom_range(0, 10);
      body.push_back({1'($urandom_range(0, 9) == 0), 7'(count)});
      repeat (count) begin
         if (digits && $urandom_range(0, 99) < 90)
            body.push_back(8'(hrfs_pkg::ASCII_ZERO[7:0] + $urandom_range(0, 9)));
         else
            body.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic random_frame(input logic [5:0] name_index);
      logic [7:0]  body[$];
      logic [5:0]  idx;
      logic [23:0] length;
      int unsigned r;
      repeat ($urandom_range(1, 6)) begin
         r = $urandom_range(0, 99);
         if (r < 28) begin
            body.push_back({1'b1, 7'($urandom_range(0, 7))});
         end else if (r < 35) begin
            body.push_back({1'b1, 7'($urandom_range(0, 127))});
         end else if (r < 90) begin
            case ($urandom_range(0, 3))
               0: idx = 6'd0;
               3: idx = 6'($urandom_range(1, 63));
               default: idx = name_index;
            endcase
            if (idx <= 6'd15 && $urandom_range(0, 1) == 1)
               body.push_back({3'b000, 1'($urandom_range(0, 1)), idx[3:0]});
            else
               body.push_back({2'b01, idx});
            if (idx == 6'd0) add_string(body, 1'b0);
            add_string(body, idx == name_index);
         end else if (r < 97) begin
            body.push_back({3'b001, 5'($urandom_range(0, 31))});
         end else begin
            body.push_back(8'($urandom_range(0, 255)));
         end
      end
      r = $urandom_range(0, 99);
      if (r < 80) length = 24'(body.size());
      else if (r < 88) length = 24'($urandom_range(0, body.size()));
      else if (r < 94) length = 24'(body.size() + $urandom_range(1, 5));
      else length = 24'($urandom);
      push_frame(body, length);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_valid <= 1'b0;
         send_gap <= 0;
         settle_count <= 0;
         stim_done <= 1'b0;
      end else if (!((req_tvalid && !req_tready) || (csr_valid && !csr_ready))) begin
         if (send_gap != 0) begin
            req_tvalid <= 1'b0;
            csr_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (send_plan.size() == 0) begin
            req_tvalid <= 1'b0;
            csr_valid <= 1'b0;
            stim_done <= 1'b1;
         end else begin
            case (send_plan[0].kind)
               PLAN_BYTE: begin
                  req_tvalid <= 1'b1;
                  req_tdata <= send_plan[0].value;
                  req_tuser <= send_plan[0].first;
                  csr_valid <= 1'b0;
                  send_gap <= pick_gap();
                  void'(send_plan.pop_front());
               end
               PLAN_DRAIN: begin
                  req_tvalid <= 1'b0;
                  csr_valid <= 1'b0;
                  if (field_reports.size() != 0) begin
                     settle_count <= 0;
                  end else if (settle_count == SETTLE_CYCLES) begin
                     settle_count <= 0;
                     void'(send_plan.pop_front());
                  end else begin
                     settle_count <= settle_count + 1;
                  end
               end
               default: begin
                  req_tvalid <= 1'b0;
                  csr_valid <= 1'b1;
                  csr_data <= send_plan[0].value[5:0];
                  void'(send_plan.pop_front());
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      hrfs_pkg::result_type want;
      if (reset) begin
         clear_scan();
         length_index_model = hrfs_pkg::LENGTH_INDEX_RESET;
         field_reports.delete();
      end else begin
         if (csr_valid && csr_ready) length_index_model = csr_data;
         if (req_tvalid && req_tready) scan_byte(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            if (field_reports.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual %h status %0d",
                        $time, rsp_tdata, rsp_tuser);
               mismatch_seen = 1'b1;
            end else begin
               want = field_reports.pop_front();
               check_field("method", 32'(want.method), 32'(rsp_tdata[1:0]));
               check_field("path_kind", 32'(want.path_kind), 32'(rsp_tdata[3:2]));
               check_field("decimal_length", want.decimal_length, rsp_tdata[35:4]);
               check_field("length_seen", 32'(want.length_seen), 32'(rsp_tdata[36]));
               check_field("length_huffman", 32'(want.length_huffman), 32'(rsp_tdata[37]));
               check_field("status", 32'(want.status), 32'(rsp_tuser));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [7:0]  body[$];
      logic [5:0]  name_index;
      int unsigned phase_target;

      add_item(8'hFF, 1'b0);
      body.delete();
      push_frame(body, 24'd0);
      body = {8'h83, 8'h85, 8'h82, 8'h84, 8'h5C, 8'h03, 8'h31, 8'h32, 8'h33};
      push_frame(body, 24'(body.size()));
      body = {8'h00, 8'h81, 8'hE1, 8'h00, 8'h5C, 8'h83, 8'hFF, 8'h00, 8'h7F, 8'h3F};
      push_frame(body, 24'(body.size() + 2));
      body = {8'h82, 8'h5C, 8'h05, 8'h39, 8'h38};
      push_frame(body, 24'(body.size()));

      name_index = hrfs_pkg::LENGTH_INDEX_RESET;
      for (int p = 0; p < PHASES; p++) begin
         if (p != 0) begin
            body.delete();
            push_frame(body, 24'd0);
            add_drain();
            case (p)
               1: name_index = 6'd1;
               2: name_index = 6'd61;
               3: name_index = 6'd15;
               4: name_index = 6'd16;
               default: name_index = 6'($urandom_range(1, 61));
            endcase
            add_csr(name_index);
         end
         phase_target = plan_bytes + ITEM_TARGET / PHASES;
         while (plan_bytes < phase_target) begin
            if ($urandom_range(0, 19) == 0) add_item(8'($urandom_range(0, 255)), 1'b0);
            random_frame(name_index);
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock);
      while (reset || !stim_done || field_reports.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (!mismatch_seen) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
